### rtl/tlptm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_pkg
// Shared types and codes for the two-level page table manager: command and
// status codes, request and result transfer layouts.
// ============================================================================
package tlptm_pkg;

    localparam int unsigned VA_W       = 32;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned FLAGS_W    = 12;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned IN_USE_W   = 5;
    localparam int unsigned PRESENT    = 0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POOL_EMPTY = 2'd1,
        ST_NOT_MAPPED = 2'd2,
        ST_DISABLED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [VA_W-1:0]    vaddr;
        logic [VA_W-1:0]    paddr;
        logic [FLAGS_W-1:0] flags;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [VA_W-1:0]     translated_addr;
        logic                is_mapped;
        logic [COUNT_W-1:0]  mapped_count;
        logic [IN_USE_W-1:0] tables_in_use;
    } result_t;

endpackage

### rtl/two_level_page_table_manager.sv
`timescale 1ns / 1ps
// ============================================================================
// two_level_page_table_manager
// Keeps a 1024-slot page directory and a pool of MAX_TABLES page tables in
// on-chip memory; maps, unmaps and translates 4 KiB pages one command at a time.
// ============================================================================
// Usage:
//   Request channel: drive request and raise start; the transfer happens at
//   the rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it.
//   Configuration: cfg_wr_en writes cfg_wr_data into the enable register;
//   write only while no command is in flight.
//   Sequencing: the walk is set by the two dependent memory reads, the
//   directory read and then the page table read, followed by write-back;
//   done is registered from the write-back state, and a new request is
//   taken in the cycle done is shown, not before.
//   Reset: a clearing pass over every table memory address zeroes the table
//   memory and the directory; busy stays high until it completes.
//   When disabled, commands change nothing and report status disabled.
// ============================================================================
module two_level_page_table_manager #(
    parameter int unsigned MAX_TABLES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tlptm_pkg::request_t  request,
    output logic                 done,
    output tlptm_pkg::result_t   result,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);

    localparam int unsigned INDEX_W = tlptm_pkg::INDEX_W;
    localparam int unsigned SLOTS   = 2 ** INDEX_W;
    localparam int unsigned DIR_W   = $clog2(MAX_TABLES + 1);
    localparam int unsigned TBL_W   = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int unsigned ADDR_W  = TBL_W + INDEX_W;
    localparam int unsigned DEPTH   = MAX_TABLES * SLOTS;
    localparam int unsigned VA_W    = tlptm_pkg::VA_W;
    localparam int unsigned OFF_W   = tlptm_pkg::OFFSET_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [DIR_W-1:0]  POOL_MAX  = DIR_W'(MAX_TABLES);
    localparam logic [DIR_W-1:0]  DIR_ONE   = DIR_W'(1);
    localparam logic [tlptm_pkg::COUNT_W-1:0] CNT_ONE = 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIR   = 4'b0100,
        S_TBL   = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clear_cnt_reg, clear_cnt_next;
    logic                        enabled_reg;
    tlptm_pkg::request_t         req_reg;
    logic [tlptm_pkg::COUNT_W-1:0] pages_reg, pages_next;
    logic [DIR_W-1:0]            alloc_reg, alloc_next;
    logic                        hit_reg, hit_next;
    logic                        pool_full_reg, pool_full_next;
    logic                        done_reg;
    tlptm_pkg::result_t          result_reg, result_next;

    logic [DIR_W-1:0]            dir_mem [SLOTS];
    logic [DIR_W-1:0]            dir_rdata_reg;
    logic                        dir_we;
    logic [INDEX_W-1:0]          dir_waddr;
    logic [DIR_W-1:0]            dir_wdata;

    logic [VA_W-1:0]             tbl_mem [DEPTH];
    logic [VA_W-1:0]             tbl_rdata_reg;
    logic [ADDR_W-1:0]           tbl_raddr;
    logic [ADDR_W-1:0]           taddr_reg;
    logic                        tbl_we;
    logic [ADDR_W-1:0]           tbl_waddr;
    logic [VA_W-1:0]             tbl_wdata;

    logic                        dir_present;
    logic                        alloc_ok;
    logic                        entry_present;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rdata_reg <= dir_mem[request.vaddr[VA_W-1 -: INDEX_W]];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata_reg <= tbl_mem[tbl_raddr];
    end

    assign dir_present   = (dir_rdata_reg != '0);
    assign alloc_ok      = (alloc_reg < POOL_MAX);
    assign entry_present = hit_reg && tbl_rdata_reg[tlptm_pkg::PRESENT];

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        pages_next     = pages_reg;
        alloc_next     = alloc_reg;
        hit_next       = hit_reg;
        pool_full_next = pool_full_reg;
        result_next    = result_reg;
        dir_we         = 1'b0;
        dir_waddr      = req_reg.vaddr[VA_W-1 -: INDEX_W];
        dir_wdata      = alloc_reg + DIR_ONE;
        tbl_we         = 1'b0;
        tbl_waddr      = taddr_reg;
        tbl_wdata      = '0;
        tbl_raddr      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                dir_we     = 1'b1;
                dir_waddr  = clear_cnt_reg[INDEX_W-1:0];
                dir_wdata  = '0;
                tbl_we     = 1'b1;
                tbl_waddr  = clear_cnt_reg;
                clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
                if (clear_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                hit_next       = dir_present;
                pool_full_next = 1'b0;
                if (dir_present)
                begin
                    tbl_raddr = {TBL_W'(dir_rdata_reg - DIR_ONE),
                                 req_reg.vaddr[OFF_W +: INDEX_W]};
                end
                else if (enabled_reg && (req_reg.command == tlptm_pkg::CMD_MAP))
                begin
                    if (alloc_ok)
                    begin
                        hit_next   = 1'b1;
                        dir_we     = 1'b1;
                        alloc_next = alloc_reg + DIR_ONE;
                        tbl_raddr  = {TBL_W'(alloc_reg),
                                      req_reg.vaddr[OFF_W +: INDEX_W]};
                    end
                    else
                    begin
                        pool_full_next = 1'b1;
                    end
                end
                state_next = S_TBL;
            end
            S_TBL:
            begin
                result_next.status          = tlptm_pkg::ST_OK;
                result_next.translated_addr = '0;
                result_next.is_mapped       = 1'b0;
                if (!enabled_reg)
                begin
                    result_next.status = tlptm_pkg::ST_DISABLED;
                end
                else
                begin
                    unique case (req_reg.command)
                        tlptm_pkg::CMD_MAP:
                        begin
                            if (pool_full_reg)
                            begin
                                result_next.status = tlptm_pkg::ST_POOL_EMPTY;
                            end
                            else
                            begin
                                tbl_we    = 1'b1;
                                tbl_wdata = {req_reg.paddr[VA_W-1:OFF_W],
                                             req_reg.flags};
                                if (pages_reg != tlptm_pkg::COUNT_MAX)
                                begin
                                    pages_next = pages_reg + CNT_ONE;
                                end
                                result_next.is_mapped = req_reg.flags[tlptm_pkg::PRESENT];
                            end
                        end
                        tlptm_pkg::CMD_UNMAP:
                        begin
                            if (entry_present)
                            begin
                                tbl_we    = 1'b1;
                                tbl_wdata = '0;
                                if (pages_reg != '0)
                                begin
                                    pages_next = pages_reg - CNT_ONE;
                                end
                            end
                            else
                            begin
                                result_next.status = tlptm_pkg::ST_NOT_MAPPED;
                            end
                        end
                        default:
                        begin
                            if (entry_present)
                            begin
                                result_next.translated_addr =
                                    {tbl_rdata_reg[VA_W-1:OFF_W],
                                     req_reg.vaddr[OFF_W-1:0]};
                                result_next.is_mapped = 1'b1;
                            end
                            else
                            begin
                                result_next.status = tlptm_pkg::ST_NOT_MAPPED;
                            end
                        end
                    endcase
                end
                result_next.mapped_count  = pages_next;
                result_next.tables_in_use = tlptm_pkg::IN_USE_W'(alloc_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            enabled_reg   <= 1'b0;
            pages_reg     <= '0;
            alloc_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            pages_reg     <= pages_next;
            alloc_reg     <= alloc_next;
            done_reg      <= (state_reg == S_TBL);
            if (cfg_wr_en)
            begin
                enabled_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (state_reg == S_DIR)
        begin
            taddr_reg <= tbl_raddr;
        end
        hit_reg       <= hit_next;
        pool_full_reg <= pool_full_next;
        result_reg    <= result_next;
    end

`ifndef SYNTHESIS
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_TBL))
        else $error("result strobe without a completed walk");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= POOL_MAX)
        else $error("table pool count beyond pool size");

    a_count_moves_on_walk: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(pages_reg) |-> $past(state_reg == S_TBL))
        else $error("page count changed outside write-back");

    a_alloc_on_map: assert property (@(posedge clk) disable iff (!rst_n)
        (dir_we && (state_reg == S_DIR)) |->
            (enabled_reg && (req_reg.command == tlptm_pkg::CMD_MAP) && alloc_ok))
        else $error("directory slot allocated outside an enabled map");
`endif

endmodule
